FILE: design/dpb_pkg.sv
// shared types and constants of the depth back-projection unit
`timescale 1ns / 1ps
`default_nettype none
package dpb_pkg;

    localparam int DEPTH_W  = 16;
    localparam int SCALE_W  = 24;
    localparam int CENTER_W = 16;
    localparam int INV_W    = 24;
    localparam int SIZE_W   = 13;
    localparam int Z_W      = 40;
    localparam int MAG_W    = 52;
    localparam int COORD_W  = 53;
    localparam int TALLY_W  = 25;
    localparam int PROD_W   = 56;
    localparam int MUL_A_W  = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd6;

    localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE  = 24'd65536;
    localparam logic [CENTER_W-1:0] RST_CENTER_X     = 16'd5120;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 16'd3840;
    localparam logic [SIZE_W-1:0]   RST_FRAME_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0]   RST_FRAME_HEIGHT = 13'd480;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [SCALE_W-1:0]  depth_scale;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [INV_W-1:0]    inv_focal_x;
        logic [INV_W-1:0]    inv_focal_y;
        logic [SIZE_W-1:0]   frame_width;
        logic [SIZE_W-1:0]   frame_height;
    } cfg_t;

    // one classified pixel on its way from front to back
    typedef struct packed {
        logic [DEPTH_W-1:0]  depth;
        logic [CENTER_W-1:0] diff_x;
        logic                neg_x;
        logic [CENTER_W-1:0] diff_y;
        logic                neg_y;
        logic                point_valid;
        logic                frame_end;
        logic [TALLY_W-1:0]  valid_points;
    } job_t;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_Z    = 10'b00_0000_0010,
        ST_MX   = 10'b00_0000_0100,
        ST_HX   = 10'b00_0000_1000,
        ST_LX   = 10'b00_0001_0000,
        ST_MY   = 10'b00_0010_0000,
        ST_HY   = 10'b00_0100_0000,
        ST_LY   = 10'b00_1000_0000,
        ST_FIN  = 10'b01_0000_0000,
        ST_OUT  = 10'b10_0000_0000
    } back_state_t;

endpackage
`default_nettype wire

FILE: design/dpb_if.sv
// stream interfaces for depth pixels in and points out
`timescale 1ns / 1ps
`default_nettype none
interface dpb_pixel_if;
    logic        valid;
    logic        ready;
    logic [15:0] depth;

    modport source (output valid, output depth, input ready);
    modport sink   (input valid, input depth, output ready);
endinterface

interface dpb_point_if;
    logic               valid;
    logic               ready;
    logic               point_valid;
    logic signed [52:0] x_coord;
    logic signed [52:0] y_coord;
    logic [39:0]        z_coord;
    logic               frame_end;
    logic [24:0]        valid_points;

    modport source (output valid, output point_valid, output x_coord, output y_coord,
                    output z_coord, output frame_end, output valid_points, input ready);
    modport sink   (input valid, input point_valid, input x_coord, input y_coord,
                    input z_coord, input frame_end, input valid_points, output ready);
endinterface
`default_nettype wire

FILE: design/dpb_front.sv
// front end: raster counters, pixel classification and frame tally
`timescale 1ns / 1ps
`default_nettype none
module dpb_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire dpb_pkg::cfg_t    cfg,
    dpb_pixel_if.sink             pixels,
    output logic                  push_valid,
    output dpb_pkg::job_t         push_job,
    input  wire                   push_ready
);

    localparam int ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [dpb_pkg::SIZE_W-1:0] MaxW = dpb_pkg::SIZE_W'(MAX_WIDTH);
    localparam logic [dpb_pkg::SIZE_W-1:0] MaxH = dpb_pkg::SIZE_W'(MAX_HEIGHT);

    logic [ColW-1:0]                col_reg, col_next;
    logic [RowW-1:0]                row_reg, row_next;
    logic [dpb_pkg::TALLY_W-1:0]    tally_reg, tally_next;
    logic [dpb_pkg::SIZE_W-1:0]     width_c, height_c;
    logic                           row_last, frame_last, pix_ok, accept;
    logic [dpb_pkg::TALLY_W-1:0]    tally_inc;
    logic [dpb_pkg::CENTER_W-1:0]   col_pos, row_pos;

    assign pixels.ready = push_ready;
    assign push_valid   = pixels.valid;
    assign accept       = pixels.valid && push_ready;

    always_comb
    begin
        // frame size clamped to 1..max
        priority if (cfg.frame_width == '0)
            width_c = dpb_pkg::SIZE_W'(1);
        else if (cfg.frame_width > MaxW)
            width_c = MaxW;
        else
            width_c = cfg.frame_width;

        priority if (cfg.frame_height == '0)
            height_c = dpb_pkg::SIZE_W'(1);
        else if (cfg.frame_height > MaxH)
            height_c = MaxH;
        else
            height_c = cfg.frame_height;
    end

    assign row_last   = (dpb_pkg::SIZE_W'(col_reg) + dpb_pkg::SIZE_W'(1)) >= width_c;
    assign frame_last = row_last
                        && ((dpb_pkg::SIZE_W'(row_reg) + dpb_pkg::SIZE_W'(1)) >= height_c);
    assign pix_ok     = (pixels.depth != '0) && (cfg.depth_scale != '0)
                        && (cfg.inv_focal_x != '0) && (cfg.inv_focal_y != '0);
    assign tally_inc  = pix_ok ? tally_reg + dpb_pkg::TALLY_W'(1) : tally_reg;

    // pixel position in q12.4
    assign col_pos = dpb_pkg::CENTER_W'({col_reg, 4'b0000});
    assign row_pos = dpb_pkg::CENTER_W'({row_reg, 4'b0000});

    always_comb
    begin
        push_job.depth        = pixels.depth;
        push_job.neg_x        = col_pos < cfg.center_x;
        push_job.diff_x       = push_job.neg_x ? cfg.center_x - col_pos : col_pos - cfg.center_x;
        push_job.neg_y        = row_pos < cfg.center_y;
        push_job.diff_y       = push_job.neg_y ? cfg.center_y - row_pos : row_pos - cfg.center_y;
        push_job.point_valid  = pix_ok;
        push_job.frame_end    = frame_last;
        push_job.valid_points = tally_inc;
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        tally_next = tally_reg;
        if (accept)
        begin
            priority if (frame_last)
            begin
                col_next   = '0;
                row_next   = '0;
                tally_next = '0;
            end
            else if (row_last)
            begin
                col_next   = '0;
                row_next   = row_reg + RowW'(1);
                tally_next = tally_inc;
            end
            else
            begin
                col_next   = col_reg + ColW'(1);
                tally_next = tally_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            tally_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            tally_reg <= tally_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/dpb_queue.sv
// two-entry queue of classified pixels between front and back
`timescale 1ns / 1ps
`default_nettype none
module dpb_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push_valid,
    input  wire dpb_pkg::job_t    push_job,
    output logic                  push_ready,
    output logic                  pop_valid,
    output dpb_pkg::job_t         pop_job,
    input  wire                   pop
);

    localparam int PtrW = $clog2(dpb_pkg::QUEUE_DEPTH);
    localparam int CntW = $clog2(dpb_pkg::QUEUE_DEPTH + 1);

    dpb_pkg::job_t       entry_reg [dpb_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = count_reg != CntW'(dpb_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PtrW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PtrW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CntW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CntW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule
`default_nettype wire

FILE: design/dpb_back.sv
// back end: sequencer around one shared multiplier, output register
`timescale 1ns / 1ps
`default_nettype none
module dpb_back (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire dpb_pkg::cfg_t    cfg,
    input  wire                   job_valid,
    input  wire dpb_pkg::job_t    job,
    output logic                  job_pop,
    dpb_point_if.source           points
);

    dpb_pkg::back_state_t           state_reg, state_next;
    dpb_pkg::job_t                  job_reg;
    logic [dpb_pkg::PROD_W-1:0]     prod_reg, m_reg;
    logic [dpb_pkg::Z_W-1:0]        z_reg;
    logic [dpb_pkg::MAG_W-1:0]      hi_reg, x_mag_reg, y_mag_reg, mag_sum;
    logic [dpb_pkg::MUL_A_W-1:0]    mul_a;
    logic [dpb_pkg::INV_W-1:0]      mul_b;
    logic [63:0]                    mul_full;
    logic                           out_fire, out_valid_reg;
    logic [dpb_pkg::COORD_W-1:0]    x_ext, y_ext;

    assign job_pop  = (state_reg == dpb_pkg::ST_IDLE) && job_valid;
    assign out_fire = (state_reg == dpb_pkg::ST_OUT) && (!out_valid_reg || points.ready);

    // operand select for the shared 40x24 multiplier
    always_comb
    begin
        unique case (state_reg)
            dpb_pkg::ST_Z:
            begin
                mul_a = dpb_pkg::MUL_A_W'(job_reg.depth);
                mul_b = cfg.depth_scale;
            end
            dpb_pkg::ST_MX:
            begin
                mul_a = prod_reg[dpb_pkg::Z_W-1:0];
                mul_b = dpb_pkg::INV_W'(job_reg.diff_x);
            end
            dpb_pkg::ST_HX:
            begin
                mul_a = dpb_pkg::MUL_A_W'(prod_reg[55:28]);
                mul_b = cfg.inv_focal_x;
            end
            dpb_pkg::ST_LX:
            begin
                mul_a = dpb_pkg::MUL_A_W'(m_reg[27:0]);
                mul_b = cfg.inv_focal_x;
            end
            dpb_pkg::ST_MY:
            begin
                mul_a = z_reg;
                mul_b = dpb_pkg::INV_W'(job_reg.diff_y);
            end
            dpb_pkg::ST_HY:
            begin
                mul_a = dpb_pkg::MUL_A_W'(prod_reg[55:28]);
                mul_b = cfg.inv_focal_y;
            end
            dpb_pkg::ST_LY:
            begin
                mul_a = dpb_pkg::MUL_A_W'(m_reg[27:0]);
                mul_b = cfg.inv_focal_y;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = {24'b0, mul_a} * {40'b0, mul_b};

    // high part plus low part rounded half up at bit 27
    assign mag_sum = hi_reg + dpb_pkg::MAG_W'(prod_reg[51:28])
                     + dpb_pkg::MAG_W'(prod_reg[27]);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dpb_pkg::ST_IDLE:
                if (job_valid)
                    state_next = job.point_valid ? dpb_pkg::ST_Z : dpb_pkg::ST_OUT;
            dpb_pkg::ST_Z:   state_next = dpb_pkg::ST_MX;
            dpb_pkg::ST_MX:  state_next = dpb_pkg::ST_HX;
            dpb_pkg::ST_HX:  state_next = dpb_pkg::ST_LX;
            dpb_pkg::ST_LX:  state_next = dpb_pkg::ST_MY;
            dpb_pkg::ST_MY:  state_next = dpb_pkg::ST_HY;
            dpb_pkg::ST_HY:  state_next = dpb_pkg::ST_LY;
            dpb_pkg::ST_LY:  state_next = dpb_pkg::ST_FIN;
            dpb_pkg::ST_FIN: state_next = dpb_pkg::ST_OUT;
            dpb_pkg::ST_OUT:
                if (out_fire)
                    state_next = dpb_pkg::ST_IDLE;
            default:         state_next = dpb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dpb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_fire)
                out_valid_reg <= 1'b1;
            else if (points.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[dpb_pkg::PROD_W-1:0];
        if (job_pop)
        begin
            job_reg   <= job;
            z_reg     <= '0;
            x_mag_reg <= '0;
            y_mag_reg <= '0;
        end
        if (state_reg == dpb_pkg::ST_MX)
            z_reg <= prod_reg[dpb_pkg::Z_W-1:0];
        if (state_reg == dpb_pkg::ST_HX || state_reg == dpb_pkg::ST_HY)
            m_reg <= prod_reg;
        if (state_reg == dpb_pkg::ST_LX || state_reg == dpb_pkg::ST_LY)
            hi_reg <= prod_reg[dpb_pkg::MAG_W-1:0];
        if (state_reg == dpb_pkg::ST_MY)
            x_mag_reg <= mag_sum;
        if (state_reg == dpb_pkg::ST_FIN)
            y_mag_reg <= mag_sum;
    end

    assign x_ext = {1'b0, x_mag_reg};
    assign y_ext = {1'b0, y_mag_reg};

    logic                           pv_reg, fe_reg;
    logic [dpb_pkg::COORD_W-1:0]    x_reg, y_reg;
    logic [dpb_pkg::Z_W-1:0]        zo_reg;
    logic [dpb_pkg::TALLY_W-1:0]    vp_reg;

    always_ff @(posedge clk)
    begin
        if (out_fire)
        begin
            pv_reg <= job_reg.point_valid;
            x_reg  <= job_reg.neg_x ? (~x_ext + dpb_pkg::COORD_W'(1)) : x_ext;
            y_reg  <= job_reg.neg_y ? (~y_ext + dpb_pkg::COORD_W'(1)) : y_ext;
            zo_reg <= z_reg;
            fe_reg <= job_reg.frame_end;
            vp_reg <= job_reg.valid_points;
        end
    end

    assign points.valid        = out_valid_reg;
    assign points.point_valid  = pv_reg;
    assign points.x_coord      = x_reg;
    assign points.y_coord      = y_reg;
    assign points.z_coord      = zo_reg;
    assign points.frame_end    = fe_reg;
    assign points.valid_points = vp_reg;

endmodule
`default_nettype wire

FILE: design/depth_to_point_backprojection_unit.sv
// pinhole depth back-projection: one depth pixel in, one 3d point out
// a valid pixel steps the back end through states Z, MX, HX, LX, MY, HY, LY, FIN and OUT; an invalid one goes to OUT
// the back end takes the next pixel only after the point of the last one has entered the output register
// the back-end sequencer uses one 40x24 multiplier seven times for a valid pixel
// front end takes pixels into a 2-entry queue while the back end is busy
// reset clears counters, tally, queue and output valid; config registers return to their defaults
`timescale 1ns / 1ps
`default_nettype none
module depth_to_point_backprojection_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_write,
    input  wire [dpb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [dpb_pkg::CFG_DATA_W-1:0]     cfg_data,
    dpb_pixel_if.sink                         pixels,
    dpb_point_if.source                       points
);

    dpb_pkg::cfg_t  cfg_reg;
    logic           push_valid, push_ready, pop_valid, pop;
    dpb_pkg::job_t  push_job, pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_scale  <= dpb_pkg::RST_DEPTH_SCALE;
            cfg_reg.center_x     <= dpb_pkg::RST_CENTER_X;
            cfg_reg.center_y     <= dpb_pkg::RST_CENTER_Y;
            cfg_reg.inv_focal_x  <= '0;
            cfg_reg.inv_focal_y  <= '0;
            cfg_reg.frame_width  <= dpb_pkg::RST_FRAME_WIDTH;
            cfg_reg.frame_height <= dpb_pkg::RST_FRAME_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dpb_pkg::REG_DEPTH_SCALE:  cfg_reg.depth_scale  <= cfg_data;
                dpb_pkg::REG_CENTER_X:     cfg_reg.center_x     <= cfg_data[15:0];
                dpb_pkg::REG_CENTER_Y:     cfg_reg.center_y     <= cfg_data[15:0];
                dpb_pkg::REG_INV_FOCAL_X:  cfg_reg.inv_focal_x  <= cfg_data;
                dpb_pkg::REG_INV_FOCAL_Y:  cfg_reg.inv_focal_y  <= cfg_data;
                dpb_pkg::REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data[12:0];
                dpb_pkg::REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    dpb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pixels     (pixels),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    dpb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job),
        .pop        (pop)
    );

    dpb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .job_valid  (pop_valid),
        .job        (pop_job),
        .job_pop    (pop),
        .points     (points)
    );

endmodule
`default_nettype wire

FILE: design/dpb_checker.sv
// port-level checks for the back-projection unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module dpb_checker (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              out_valid,
    input  wire              out_ready,
    input  wire              point_valid,
    input  wire [52:0]       x_coord,
    input  wire [52:0]       y_coord,
    input  wire [39:0]       z_coord,
    input  wire              frame_end,
    input  wire [24:0]       valid_points
);

    // nothing is offered while reset is held
    a_quiet_in_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("point offered during reset");

    // a stalled point keeps its payload
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(x_coord) && $stable(y_coord)
        && $stable(z_coord) && $stable(point_valid) && $stable(frame_end)
        && $stable(valid_points))
        else $error("stalled point changed");

    // a pixel without a point carries zero coordinates
    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> x_coord == '0 && y_coord == '0 && z_coord == '0)
        else $error("invalid point has nonzero coordinates");

    // a real point has depth and is counted
    a_counted_when_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_valid |-> z_coord != '0 && valid_points != '0)
        else $error("valid point with zero depth or zero count");

endmodule

bind depth_to_point_backprojection_unit dpb_checker u_dpb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (points.valid),
    .out_ready    (points.ready),
    .point_valid  (points.point_valid),
    .x_coord      (points.x_coord),
    .y_coord      (points.y_coord),
    .z_coord      (points.z_coord),
    .frame_end    (points.frame_end),
    .valid_points (points.valid_points)
);
`default_nettype wire
